/* design/setp_pkg.sv */
// setp_pkg: shared types and constants of the scored eviction tag pool.
// Used by setp_ctrl, setp_datapath and scored_eviction_tag_pool; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package setp_pkg;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_ACTIVE  = 2'd1,
        ST_AGED    = 2'd2,
        ST_EVICTED = 2'd3
    } t_slot_st;

    localparam logic [1:0] MODE_PUT = 2'd0;
    localparam logic [1:0] MODE_GET = 2'd1;

    localparam logic [1:0] CFG_HALF_LIFE = 2'd0;
    localparam logic [1:0] CFG_FULL_LIFE = 2'd1;
    localparam logic [1:0] CFG_MAX_POINTS = 2'd2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int KEY_W   = 64;
    localparam int SEC_W   = 16;
    localparam int TAG_W   = 16;
    localparam int CNT_W   = 13;
    localparam int TIME_W  = 64;
    localparam int HITS_W  = 4;
    localparam int PTS_W   = 10;
    localparam int SUM_W   = 16;
    localparam int CTR_W   = 64;
    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int POP_W   = 7;
    localparam int THR_W   = 52;

    localparam int MAX_PLAN_ENTRIES = 4096;
    localparam logic [THR_W-CFG_DATA_W-1:0] NS_PER_MS = 20'd1000000;
    localparam logic [PTS_W-1:0] POINTS_MAX = 10'd1023;
    localparam logic [HITS_W-1:0] HITS_MAX = 4'd15;
    localparam logic [HITS_W-1:0] HIT_CAP = 4'd10;
    localparam logic [HITS_W-1:0] SCORE_BASE = 4'd10;

    // ceil(c*16/100) = ((c*16 + 99) * RECIP_100) >> RECIP_SH
    localparam int PT_X_W = 18;
    localparam logic [PT_X_W-1:0] PT_ROUND = 18'd99;
    localparam logic [PT_X_W-1:0] RECIP_100 = 18'd167773;
    localparam int RECIP_SH = 24;

    // age_ns / 1e9 by restoring division, several quotient bits per cycle
    localparam int QUO_W = 35;
    localparam int REM_W = 30;
    localparam int DIV_STEPS = 5;
    localparam int DIV_CYCLES = QUO_W / DIV_STEPS;
    localparam int DIV_CNT_W = 3;
    localparam logic [REM_W:0] NS_PER_S = 31'd1000000000;
    localparam int SCORE_W = QUO_W + 1;

    // tdata layout, lowest bit first
    localparam int IN_KH_LSB  = 0;
    localparam int IN_KL_LSB  = IN_KH_LSB + KEY_W;
    localparam int IN_SEC_LSB = IN_KL_LSB + KEY_W;
    localparam int IN_TAG_LSB = IN_SEC_LSB + SEC_W;
    localparam int IN_CNT_LSB = IN_TAG_LSB + TAG_W;
    localparam int IN_NOW_LSB = IN_CNT_LSB + CNT_W;
    localparam int IN_DATA_W  = 240;

    localparam int OUT_SLOT_LSB = 0;
    localparam int OUT_CNT_LSB  = OUT_SLOT_LSB + SLOT_W;
    localparam int OUT_DROP_LSB = OUT_CNT_LSB + CNT_W;
    localparam int OUT_POP_LSB  = OUT_DROP_LSB + 1;
    localparam int OUT_PTS_LSB  = OUT_POP_LSB + POP_W;
    localparam int OUT_HIT_LSB  = OUT_PTS_LSB + SUM_W;
    localparam int OUT_MISS_LSB = OUT_HIT_LSB + CTR_W;
    localparam int OUT_EVC_LSB  = OUT_MISS_LSB + CTR_W;
    localparam int OUT_AGE_LSB  = OUT_EVC_LSB + CTR_W;
    localparam int OUT_USED_W   = OUT_AGE_LSB + CTR_W;
    localparam int OUT_DATA_W   = 304;

    typedef struct packed {
        logic [KEY_W-1:0]  key_high;
        logic [KEY_W-1:0]  key_low;
        logic [SEC_W-1:0]  section;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] put_time;
        logic [TIME_W-1:0] last_use;
        logic [HITS_W-1:0] hits;
        logic [PTS_W-1:0]  points;
        logic [CNT_W-1:0]  count;
    } t_entry;

    typedef struct packed {
        logic load;
        logic prep;
        logic scan_start;
        logic sweep;
        logic match;
        logic score;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic need_score;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* design/setp_ctrl.sv */
// setp_ctrl: sequencer of one request: capture, setup, sweep pass, match pass,
// optional scoring pass, commit. Depends on setp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module setp_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  setp_pkg::t_sts    i_sts,
    output setp_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PREP   = 6'b000010,
        S_SWEEP  = 6'b000100,
        S_MATCH  = 6'b001000,
        S_SCORE  = 6'b010000,
        S_COMMIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.need_score) begin
                        o_cmd.scan_start = 1'b1;
                        n_state = S_SCORE;
                    end else begin
                        n_state = S_COMMIT;
                    end
                end
            end
            S_SCORE: begin
                o_cmd.score = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

/* design/setp_datapath.sv */
// setp_datapath: slot memory, status flops, scan engine, score divider,
// counters, config registers and result register. Depends on setp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module setp_datapath #(
    parameter int SLOTS = 64
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  setp_pkg::t_cmd                         i_cmd,
    output setp_pkg::t_sts                         o_sts,
    input  wire [setp_pkg::IN_DATA_W-1:0]          i_in_data,
    input  wire [setp_pkg::MODE_W-1:0]             i_in_mode,
    input  wire                                    i_cfg_wr_en,
    input  wire [setp_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  wire [setp_pkg::CFG_DATA_W-1:0]         i_cfg_wr_data,
    input  wire                                    i_out_ready,
    output logic                                   o_out_valid,
    output logic [setp_pkg::OUT_DATA_W-1:0]        o_out_data,
    output logic                                   o_out_miss
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    setp_pkg::t_entry r_mem [SLOTS];
    setp_pkg::t_entry r_rd_ent;
    setp_pkg::t_slot_st r_st [SLOTS];

    logic [setp_pkg::CFG_DATA_W-1:0] r_half_ms, r_full_ms;
    logic [setp_pkg::SUM_W-1:0]      r_max_pts;
    logic [setp_pkg::THR_W-1:0]      r_half_ns, r_full_ns;

    logic [setp_pkg::MODE_W-1:0] r_mode;
    logic [setp_pkg::KEY_W-1:0]  r_kh, r_kl;
    logic [setp_pkg::SEC_W-1:0]  r_sec;
    logic [setp_pkg::TAG_W-1:0]  r_tag;
    logic [setp_pkg::CNT_W-1:0]  r_cin;
    logic [setp_pkg::TIME_W-1:0] r_now;
    logic [setp_pkg::PTS_W-1:0]  r_want;

    logic [CW-1:0] r_cnt;
    logic          r_pv;
    logic [IW-1:0] r_pidx;

    logic               r_mfound, r_ffound;
    logic [IW-1:0]      r_midx, r_fidx, r_bidx;
    setp_pkg::t_entry   r_ment;
    logic [setp_pkg::PTS_W-1:0] r_bpts;
    logic [setp_pkg::SCORE_W-1:0] r_bsc;
    logic [setp_pkg::TIME_W-1:0]  r_bage;

    logic                               r_dv_busy, r_cmp_v;
    logic [setp_pkg::DIV_CNT_W-1:0]     r_dv_cnt;
    logic [setp_pkg::REM_W-1:0]         r_dv_rem;
    logic [setp_pkg::QUO_W-1:0]         r_dv_q;
    logic [setp_pkg::TIME_W-1:0]        r_sc_age;
    logic [setp_pkg::HITS_W-1:0]        r_sc_hits;
    logic [setp_pkg::PTS_W-1:0]         r_sc_pts;
    logic [IW-1:0]                      r_sc_idx;

    logic [CW-1:0]                r_live;
    logic [setp_pkg::SUM_W-1:0]   r_pts;
    logic [setp_pkg::CTR_W-1:0]   r_hits_ctr, r_miss_ctr, r_evc_ctr, r_age_sum;

    logic r_ovalid;
    logic [setp_pkg::OUT_DATA_W-1:0] r_odata;
    logic r_omiss;

    // ---------------- combinational ----------------
    logic                          rd_en;
    logic                          rd_live;
    logic [setp_pkg::TIME_W-1:0]   el_put, el_last;
    logic                          key_eq;
    logic [setp_pkg::CNT_W-1:0]    cnt_clamp;
    logic [setp_pkg::PT_X_W-1:0]   pt_x;
    logic [2*setp_pkg::PT_X_W-1:0] pt_prod;
    logic [2*setp_pkg::PT_X_W-RECIP_SH_-1:0] pt_q;
    logic [setp_pkg::REM_W-1:0]    dv_rem;
    logic [setp_pkg::QUO_W-1:0]    dv_q;
    logic [setp_pkg::REM_W:0]      dv_t;
    logic [setp_pkg::HITS_W-1:0]   sc_h;
    logic [setp_pkg::SCORE_W-1:0]  sc_val;
    logic                          sc_better;

    localparam int RECIP_SH_ = setp_pkg::RECIP_SH;

    always_comb begin
        rd_en = 1'b0;
        if (i_cmd.sweep || i_cmd.match) begin
            rd_en = (r_cnt < SLOTS_C);
        end else if (i_cmd.score) begin
            rd_en = (r_cnt < SLOTS_C) && !r_pv && !r_dv_busy;
        end
    end

    assign rd_live = (r_st[r_pidx] == setp_pkg::ST_ACTIVE) ||
                     (r_st[r_pidx] == setp_pkg::ST_AGED);
    assign el_put  = (r_now > r_rd_ent.put_time) ? r_now - r_rd_ent.put_time : '0;
    assign el_last = (r_now > r_rd_ent.last_use) ? r_now - r_rd_ent.last_use : '0;
    assign key_eq  = (r_rd_ent.key_high == r_kh) && (r_rd_ent.key_low == r_kl) &&
                     (r_rd_ent.section == r_sec) && (r_rd_ent.tag == r_tag);

    assign cnt_clamp = (r_cin > setp_pkg::CNT_W'(setp_pkg::MAX_PLAN_ENTRIES)) ?
                       setp_pkg::CNT_W'(setp_pkg::MAX_PLAN_ENTRIES) : r_cin;
    assign pt_x    = {cnt_clamp, 4'b0000} + setp_pkg::PT_ROUND;
    assign pt_prod = pt_x * setp_pkg::RECIP_100;
    assign pt_q    = pt_prod[2*setp_pkg::PT_X_W-1:RECIP_SH_];

    always_comb begin
        dv_rem = r_dv_rem;
        dv_q = r_dv_q;
        dv_t = '0;
        for (int k = 0; k < setp_pkg::DIV_STEPS; k++) begin
            dv_t = {dv_rem, dv_q[setp_pkg::QUO_W-1]};
            dv_q = {dv_q[setp_pkg::QUO_W-2:0], 1'b0};
            if (dv_t >= setp_pkg::NS_PER_S) begin
                dv_t = dv_t - setp_pkg::NS_PER_S;
                dv_q[0] = 1'b1;
            end
            dv_rem = dv_t[setp_pkg::REM_W-1:0];
        end
    end

    assign sc_h = (r_sc_hits > setp_pkg::HIT_CAP) ? setp_pkg::HIT_CAP : r_sc_hits;
    assign sc_val = {1'b0, r_dv_q} + setp_pkg::SCORE_W'(setp_pkg::SCORE_BASE - sc_h);
    assign sc_better = (sc_val > r_bsc) || ((sc_val == r_bsc) && (r_sc_age > r_bage));

    // commit
    logic                          c_put, c_get, c_hit, c_evict, c_rm;
    logic [IW-1:0]                 c_slot;
    logic [setp_pkg::PTS_W-1:0]    c_rm_pts;
    logic [CW-1:0]                 c_live1, c_live;
    logic [setp_pkg::SUM_W-1:0]    c_pts1, c_pts;
    logic [setp_pkg::SUM_W:0]      c_pts_sum;
    logic                          c_we;
    setp_pkg::t_entry              c_ent;
    logic [setp_pkg::TIME_W-1:0]   c_age;
    logic [setp_pkg::CNT_W-1:0]    c_stored;
    logic [IW+setp_pkg::SLOT_W-1:0] c_slot_x;
    logic [CW+setp_pkg::POP_W-1:0]  c_pop_x;
    logic [setp_pkg::CTR_W-1:0]    c_hits_ctr, c_miss_ctr, c_evc_ctr, c_age_sum;

    always_comb begin
        c_put = (r_mode == setp_pkg::MODE_PUT);
        c_get = (r_mode == setp_pkg::MODE_GET);
        c_hit = c_get && r_mfound;
        c_slot = '0;
        c_evict = 1'b0;
        c_rm = 1'b0;
        c_rm_pts = r_ment.points;
        c_we = 1'b0;
        c_ent = r_ment;
        c_stored = '0;
        c_age = (r_now > r_ment.put_time) ? r_now - r_ment.put_time : '0;
        if (c_put) begin
            c_we = 1'b1;
            if (r_mfound) begin
                c_slot = r_midx;
                c_rm = 1'b1;
            end else if (r_ffound) begin
                c_slot = r_fidx;
            end else begin
                c_slot = r_bidx;
                c_rm = 1'b1;
                c_evict = 1'b1;
                c_rm_pts = r_bpts;
            end
            c_ent.key_high = r_kh;
            c_ent.key_low  = r_kl;
            c_ent.section  = r_sec;
            c_ent.tag      = r_tag;
            c_ent.put_time = r_now;
            c_ent.last_use = r_now;
            c_ent.hits     = '0;
            c_ent.points   = r_want;
            c_ent.count    = cnt_clamp;
        end else if (c_hit) begin
            c_we = 1'b1;
            c_slot = r_midx;
            c_stored = r_ment.count;
            c_ent.last_use = r_now;
            if (r_ment.hits != setp_pkg::HITS_MAX) begin
                c_ent.hits = r_ment.hits + 1'b1;
            end
            if (r_st[r_midx] == setp_pkg::ST_AGED) begin
                c_rm = 1'b1;
                c_evict = 1'b1;
            end
        end
        c_live1 = (c_rm && (r_live != '0)) ? r_live - 1'b1 : r_live;
        c_pts1 = (c_rm && (r_pts >= setp_pkg::SUM_W'(c_rm_pts))) ?
                 r_pts - setp_pkg::SUM_W'(c_rm_pts) : r_pts;
        c_pts_sum = {1'b0, c_pts1} + (setp_pkg::SUM_W + 1)'(r_want);
        c_live = c_live1;
        c_pts = c_pts1;
        if (c_put) begin
            c_live = c_live1 + 1'b1;
            c_pts = c_pts_sum[setp_pkg::SUM_W] ? '1 : c_pts_sum[setp_pkg::SUM_W-1:0];
        end
        c_hits_ctr = r_hits_ctr + setp_pkg::CTR_W'(c_hit);
        c_miss_ctr = r_miss_ctr + setp_pkg::CTR_W'(c_get && !r_mfound);
        c_evc_ctr  = r_evc_ctr + setp_pkg::CTR_W'(c_evict);
        c_age_sum  = c_hit ? r_age_sum + c_age : r_age_sum;
        c_slot_x = {{setp_pkg::SLOT_W{1'b0}}, c_slot};
        c_pop_x  = {{setp_pkg::POP_W{1'b0}}, c_live};
    end

    // ---------------- memory ----------------
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_ent <= r_mem[r_cnt[IW-1:0]];
        end
        if (i_cmd.commit && c_we) begin
            r_mem[c_slot] <= c_ent;
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_ms  <= 32'd30000;
            r_full_ms  <= 32'd60000;
            r_max_pts  <= 16'd1024;
            r_cnt      <= '0;
            r_pv       <= 1'b0;
            r_dv_busy  <= 1'b0;
            r_dv_cnt   <= '0;
            r_cmp_v    <= 1'b0;
            r_mfound   <= 1'b0;
            r_ffound   <= 1'b0;
            r_live     <= '0;
            r_pts      <= '0;
            r_hits_ctr <= '0;
            r_miss_ctr <= '0;
            r_evc_ctr  <= '0;
            r_age_sum  <= '0;
            r_ovalid   <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_st[i] <= setp_pkg::ST_FREE;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    setp_pkg::CFG_HALF_LIFE:  r_half_ms <= i_cfg_wr_data;
                    setp_pkg::CFG_FULL_LIFE:  r_full_ms <= i_cfg_wr_data;
                    setp_pkg::CFG_MAX_POINTS: r_max_pts <= i_cfg_wr_data[setp_pkg::SUM_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.scan_start) begin
                r_cnt <= '0;
                r_pv <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                r_pv <= rd_en;
            end

            if (i_cmd.prep) begin
                r_mfound <= 1'b0;
                r_ffound <= 1'b0;
            end

            // score divider sequencing
            r_cmp_v <= 1'b0;
            if (i_cmd.score && r_pv) begin
                r_dv_busy <= 1'b1;
                r_dv_cnt <= setp_pkg::DIV_CNT_W'(setp_pkg::DIV_CYCLES - 1);
            end else if (r_dv_busy) begin
                if (r_dv_cnt == '0) begin
                    r_dv_busy <= 1'b0;
                    r_cmp_v <= 1'b1;
                end else begin
                    r_dv_cnt <= r_dv_cnt - 1'b1;
                end
            end

            if (i_cmd.sweep && r_pv && rd_live) begin
                if (el_put >= setp_pkg::TIME_W'(r_full_ns)) begin
                    r_st[r_pidx] <= setp_pkg::ST_EVICTED;
                    if (r_live != '0) begin
                        r_live <= r_live - 1'b1;
                    end
                    if (r_pts >= setp_pkg::SUM_W'(r_rd_ent.points)) begin
                        r_pts <= r_pts - setp_pkg::SUM_W'(r_rd_ent.points);
                    end
                end else if ((el_put >= setp_pkg::TIME_W'(r_half_ns)) &&
                             (r_st[r_pidx] == setp_pkg::ST_ACTIVE)) begin
                    r_st[r_pidx] <= setp_pkg::ST_AGED;
                end
            end

            if (i_cmd.match && r_pv) begin
                if (rd_live && key_eq && !r_mfound) begin
                    r_mfound <= 1'b1;
                end
                if (!rd_live && !r_ffound) begin
                    r_ffound <= 1'b1;
                end
            end

            if (i_cmd.commit) begin
                if (c_put) begin
                    r_st[c_slot] <= setp_pkg::ST_ACTIVE;
                end else if (c_evict) begin
                    r_st[c_slot] <= setp_pkg::ST_EVICTED;
                end
                r_live <= c_live;
                r_pts <= c_pts;
                r_hits_ctr <= c_hits_ctr;
                r_miss_ctr <= c_miss_ctr;
                r_evc_ctr <= c_evc_ctr;
                r_age_sum <= c_age_sum;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_in_mode;
            r_kh   <= i_in_data[setp_pkg::IN_KH_LSB +: setp_pkg::KEY_W];
            r_kl   <= i_in_data[setp_pkg::IN_KL_LSB +: setp_pkg::KEY_W];
            r_sec  <= i_in_data[setp_pkg::IN_SEC_LSB +: setp_pkg::SEC_W];
            r_tag  <= i_in_data[setp_pkg::IN_TAG_LSB +: setp_pkg::TAG_W];
            r_cin  <= i_in_data[setp_pkg::IN_CNT_LSB +: setp_pkg::CNT_W];
            r_now  <= i_in_data[setp_pkg::IN_NOW_LSB +: setp_pkg::TIME_W];
        end
        if (i_cmd.prep) begin
            r_half_ns <= r_half_ms * setp_pkg::NS_PER_MS;
            r_full_ns <= r_full_ms * setp_pkg::NS_PER_MS;
            if (r_cin == '0) begin
                r_want <= setp_pkg::PTS_W'(1);
            end else if (pt_q > (2*setp_pkg::PT_X_W-RECIP_SH_)'(setp_pkg::POINTS_MAX)) begin
                r_want <= setp_pkg::POINTS_MAX;
            end else begin
                r_want <= pt_q[setp_pkg::PTS_W-1:0];
            end
        end
        if (rd_en) begin
            r_pidx <= r_cnt[IW-1:0];
        end
        if (i_cmd.match && r_pv) begin
            if (rd_live && key_eq && !r_mfound) begin
                r_midx <= r_pidx;
                r_ment <= r_rd_ent;
            end
            if (!rd_live && !r_ffound) begin
                r_fidx <= r_pidx;
            end
        end
        if (i_cmd.scan_start) begin
            r_bidx <= '0;
            r_bsc  <= '0;
            r_bage <= '0;
            r_bpts <= '0;
        end else if (r_cmp_v && sc_better) begin
            r_bidx <= r_sc_idx;
            r_bsc  <= sc_val;
            r_bage <= r_sc_age;
            r_bpts <= r_sc_pts;
        end
        if (i_cmd.score && r_pv) begin
            r_dv_rem  <= {1'b0, el_last[setp_pkg::TIME_W-1:setp_pkg::QUO_W]};
            r_dv_q    <= el_last[setp_pkg::QUO_W-1:0];
            r_sc_age  <= el_last;
            r_sc_hits <= r_rd_ent.hits;
            r_sc_pts  <= r_rd_ent.points;
            r_sc_idx  <= r_pidx;
        end else if (r_dv_busy) begin
            r_dv_rem <= dv_rem;
            r_dv_q   <= dv_q;
        end
        if (i_cmd.commit) begin
            r_odata <= '0;
            r_odata[setp_pkg::OUT_SLOT_LSB +: setp_pkg::SLOT_W] <=
                c_slot_x[setp_pkg::SLOT_W-1:0];
            r_odata[setp_pkg::OUT_CNT_LSB +: setp_pkg::CNT_W] <= c_stored;
            r_odata[setp_pkg::OUT_DROP_LSB] <= c_evict;
            r_odata[setp_pkg::OUT_POP_LSB +: setp_pkg::POP_W] <=
                c_pop_x[setp_pkg::POP_W-1:0];
            r_odata[setp_pkg::OUT_PTS_LSB +: setp_pkg::SUM_W] <= c_pts;
            r_odata[setp_pkg::OUT_HIT_LSB +: setp_pkg::CTR_W] <= c_hits_ctr;
            r_odata[setp_pkg::OUT_MISS_LSB +: setp_pkg::CTR_W] <= c_miss_ctr;
            r_odata[setp_pkg::OUT_EVC_LSB +: setp_pkg::CTR_W] <= c_evc_ctr;
            r_odata[setp_pkg::OUT_AGE_LSB +: setp_pkg::CTR_W] <= c_age_sum;
            r_omiss <= c_get && !r_mfound;
        end
    end

    assign o_sts.scan_done  = (r_cnt == SLOTS_C) && !r_pv && !r_dv_busy && !r_cmp_v;
    assign o_sts.need_score = (r_mode == setp_pkg::MODE_PUT) && !r_mfound && !r_ffound;
    assign o_sts.out_free   = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign o_out_miss  = r_omiss;

endmodule

`default_nettype wire

/* design/scored_eviction_tag_pool.sv */
// scored_eviction_tag_pool: top level; joins setp_ctrl and setp_datapath.
// Depends on setp_pkg, setp_ctrl, setp_datapath.
//
// Usage: a request enters on s_axis (tuser = mode, tdata = key, section, tag,
// count, time) and one result leaves on m_axis (tuser = miss flag, tdata =
// slot, stored count, dropped flag, population, points, four counters).
// Configuration registers are written through i_cfg_*; the user must write them
// only while the pool is idle, which the block itself does not enforce. One
// request is in work at a time. Each passes through capture, setup, a sweep
// pass and a match pass over the single-port slot memory, and commit. An
// insert that misses into a full pool adds a scoring pass that reads one slot
// at a time and waits for the score divider on each before reading the next.
// The result sits in an output register; the next request is accepted while
// it waits, and a stalled receiver holds the pool in its commit step once the
// next result is ready. Reset frees every slot at once through per-slot
// status flops and clears all counters; config returns to 30000 ms, 60000 ms
// and 1024 points.
`timescale 1ns / 1ps
`default_nettype none

module scored_eviction_tag_pool #(
    parameter int SLOTS = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // key_high, key_low, section_num, variant_tag, entry_count, now_ns
    input  wire [setp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // mode
    input  wire [setp_pkg::MODE_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // slot, stored_count, dropped_live, population, points_in_use,
    // hit_total, miss_total, eviction_total, hit_age_sum
    output logic [setp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status
    output logic                                m_axis_tuser,
    input  wire                                 i_cfg_wr_en,
    input  wire [setp_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire [setp_pkg::CFG_DATA_W-1:0]      i_cfg_wr_data
);

    setp_pkg::t_cmd cmd;
    setp_pkg::t_sts sts;

    setp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    setp_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_data     (s_axis_tdata),
        .i_in_mode     (s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata),
        .o_out_miss    (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while a request is in work");

    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata[setp_pkg::OUT_SLOT_LSB +: setp_pkg::SLOT_W] == '0) &&
        (m_axis_tdata[setp_pkg::OUT_DROP_LSB] == 1'b0))
        else $error("lookup miss reports a slot or a drop");

    a_result_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a request in work");
`endif

endmodule

`default_nettype wire

/* verif/setp_checker.sv */
// setp_checker: watches the request, result and config ports of the tag pool,
// predicts each result and compares it field by field. Depends on setp_pkg.
`timescale 1ns / 1ps

module setp_checker
    import setp_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    input  wire                   s_axis_tready,
    input  wire [IN_DATA_W-1:0]   s_axis_tdata,
    input  wire [MODE_W-1:0]      s_axis_tuser,
    input  wire                   m_axis_tvalid,
    input  wire                   m_axis_tready,
    input  wire [OUT_DATA_W-1:0]  m_axis_tdata,
    input  wire                   m_axis_tuser,
    input  wire                   i_cfg_wr_en,
    input  wire [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire [CFG_DATA_W-1:0]  i_cfg_wr_data,
    output int                    o_pending,
    output int                    o_errors
);

    localparam int NSLOT = 64;

    typedef struct {
        bit            miss;
        bit [5:0]      slot;
        bit [12:0]     stored;
        bit            dropped;
        bit [6:0]      pop;
        bit [15:0]     pts;
        bit [63:0]     hits;
        bit [63:0]     misses;
        bit [63:0]     evicts;
        bit [63:0]     age_sum;
    } t_pool_result;

    t_pool_result  pending_results[$];

    bit [31:0]     half_ms, full_ms;
    bit [15:0]     pts_budget;
    t_slot_st      st [NSLOT];
    bit [63:0]     e_kh [NSLOT], e_kl [NSLOT], e_put [NSLOT], e_use [NSLOT];
    bit [15:0]     e_sec [NSLOT], e_tag [NSLOT];
    bit [3:0]      e_hits [NSLOT];
    bit [9:0]      e_pts [NSLOT];
    bit [12:0]     e_cnt [NSLOT];
    int unsigned   live_n, pts_sum;
    bit [63:0]     n_hits, n_misses, n_evicts, n_age;

    assign o_pending = pending_results.size();

    function automatic bit is_live(int i);
        return st[i] == ST_ACTIVE || st[i] == ST_AGED;
    endfunction

    function automatic bit [63:0] age_of(bit [63:0] now, bit [63:0] then_ns);
        return now > then_ns ? now - then_ns : 64'd0;
    endfunction

    function automatic void drop_entry(int i);
        if (live_n > 0) live_n--;
        if (pts_sum >= e_pts[i]) pts_sum -= e_pts[i];
    endfunction

    function automatic int find_key(bit [63:0] kh, bit [63:0] kl, bit [15:0] sec,
                                    bit [15:0] tag);
        for (int i = 0; i < NSLOT; i++)
            if (is_live(i) && e_sec[i] == sec && e_tag[i] == tag &&
                e_kh[i] == kh && e_kl[i] == kl)
                return i;
        return -1;
    endfunction

    function automatic int choose_victim(bit [63:0] now);
        int best;
        bit [63:0] best_sc, best_age, a, sc;
        best = 0;
        best_sc = 0;
        best_age = 0;
        for (int i = 0; i < NSLOT; i++)
            if (!is_live(i)) return i;
        for (int i = 0; i < NSLOT; i++) begin
            a = age_of(now, e_use[i]);
            sc = a / 64'd1000000000 + 64'd10 - (e_hits[i] > 10 ? 64'd10 : 64'(e_hits[i]));
            if (sc > best_sc || (sc == best_sc && a > best_age)) begin
                best = i;
                best_sc = sc;
                best_age = a;
            end
        end
        return best;
    endfunction

    function automatic t_pool_result apply_request(bit [1:0] mode, bit [IN_DATA_W-1:0] d);
        t_pool_result r;
        bit [63:0] kh, kl, now, age_ms;
        bit [15:0] sec, tag;
        int unsigned cnt, want;
        int m, s;
        bit need;
        kh  = d[IN_KH_LSB +: KEY_W];
        kl  = d[IN_KL_LSB +: KEY_W];
        sec = d[IN_SEC_LSB +: SEC_W];
        tag = d[IN_TAG_LSB +: TAG_W];
        cnt = d[IN_CNT_LSB +: CNT_W];
        now = d[IN_NOW_LSB +: TIME_W];
        r = '{default: 0};
        if (cnt > MAX_PLAN_ENTRIES) cnt = MAX_PLAN_ENTRIES;
        for (int i = 0; i < NSLOT; i++) begin
            if (!is_live(i)) continue;
            age_ms = age_of(now, e_put[i]) / 64'd1000000;
            if (age_ms >= 64'(full_ms)) begin
                st[i] = ST_EVICTED;
                drop_entry(i);
            end else if (age_ms >= 64'(half_ms) && st[i] == ST_ACTIVE) begin
                st[i] = ST_AGED;
            end
        end
        if (mode == MODE_PUT) begin
            want = cnt == 0 ? 1 : (cnt * 16 + 99) / 100;
            if (want > 1023) want = 1023;
            m = find_key(kh, kl, sec, tag);
            if (m >= 0) begin
                s = m;
            end else begin
                need = live_n >= NSLOT || pts_sum + want > pts_budget;
                s = choose_victim(now);
                if (need && is_live(s)) begin
                    st[s] = ST_EVICTED;
                    drop_entry(s);
                    n_evicts++;
                    r.dropped = 1;
                end
            end
            if (is_live(s)) drop_entry(s);
            e_kh[s] = kh;
            e_kl[s] = kl;
            e_sec[s] = sec;
            e_tag[s] = tag;
            e_put[s] = now;
            e_use[s] = now;
            e_hits[s] = 0;
            e_pts[s] = want;
            e_cnt[s] = cnt;
            st[s] = ST_ACTIVE;
            live_n++;
            pts_sum += want;
            if (pts_sum > 65535) pts_sum = 65535;
            r.slot = s;
        end else if (mode == MODE_GET) begin
            m = find_key(kh, kl, sec, tag);
            if (m < 0) begin
                n_misses++;
                r.miss = 1;
            end else begin
                r.stored = e_cnt[m];
                r.slot = m;
                if (e_hits[m] < 15) e_hits[m]++;
                n_age += age_of(now, e_put[m]);
                n_hits++;
                e_use[m] = now;
                if (st[m] == ST_AGED) begin
                    st[m] = ST_EVICTED;
                    drop_entry(m);
                    n_evicts++;
                    r.dropped = 1;
                end
            end
        end
        r.pop = live_n;
        r.pts = pts_sum;
        r.hits = n_hits;
        r.misses = n_misses;
        r.evicts = n_evicts;
        r.age_sum = n_age;
        return r;
    endfunction

    function automatic void check_field(string name, bit [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_errors++;
        end
    endfunction

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_pool_result e;
        if (!i_rst_n) begin
            half_ms = 30000;
            full_ms = 60000;
            pts_budget = 1024;
            foreach (st[i]) st[i] = ST_FREE;
            live_n = 0;
            pts_sum = 0;
            n_hits = 0;
            n_misses = 0;
            n_evicts = 0;
            n_age = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_HALF_LIFE:  half_ms = i_cfg_wr_data;
                    CFG_FULL_LIFE:  full_ms = i_cfg_wr_data;
                    CFG_MAX_POINTS: pts_budget = i_cfg_wr_data[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding");
                    o_errors++;
                end else begin
                    e = pending_results.pop_front();
                    check_field("status", e.miss, m_axis_tuser);
                    check_field("slot", e.slot, m_axis_tdata[OUT_SLOT_LSB +: SLOT_W]);
                    check_field("stored_count", e.stored, m_axis_tdata[OUT_CNT_LSB +: CNT_W]);
                    check_field("dropped_live", e.dropped, m_axis_tdata[OUT_DROP_LSB]);
                    check_field("population", e.pop, m_axis_tdata[OUT_POP_LSB +: POP_W]);
                    check_field("points_in_use", e.pts, m_axis_tdata[OUT_PTS_LSB +: SUM_W]);
                    check_field("hit_total", e.hits, m_axis_tdata[OUT_HIT_LSB +: CTR_W]);
                    check_field("miss_total", e.misses, m_axis_tdata[OUT_MISS_LSB +: CTR_W]);
                    check_field("eviction_total", e.evicts,
                                m_axis_tdata[OUT_EVC_LSB +: CTR_W]);
                    check_field("hit_age_sum", e.age_sum, m_axis_tdata[OUT_AGE_LSB +: CTR_W]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(apply_request(s_axis_tuser, s_axis_tdata));
        end
    end

endmodule

/* verif/tb.sv */
// tb: drives requests and config writes into scored_eviction_tag_pool with
// random idling and gives the verdict. Depends on setp_pkg, scored_eviction_tag_pool and setp_checker.
`timescale 1ns / 1ps

module tb;
    import setp_pkg::*;

    localparam int  KEYS = 96;
    localparam int  LIMIT = 3000000;
    localparam bit [63:0] MS = 64'd1000000;

    logic                    i_clk = 0;
    logic                    i_rst_n = 0;
    logic                    s_axis_tvalid = 0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic [MODE_W-1:0]       s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    i_cfg_wr_en = 0;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wr_data = '0;
    int                      pending, errors;
    bit                      quiet = 0;
    bit [63:0]               now_ns = 0;
    bit [63:0]               pool_kh [KEYS], pool_kl [KEYS];
    bit [15:0]               pool_sec [KEYS], pool_tag [KEYS];
    int                      cycles = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    scored_eviction_tag_pool dut (.*);

    setp_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_wr_en, .i_cfg_addr, .i_cfg_wr_data,
        .o_pending(pending), .o_errors(errors)
    );

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    task automatic send_req(bit [1:0] mode, bit [63:0] kh, bit [63:0] kl, bit [15:0] sec,
                            bit [15:0] tag, bit [12:0] cnt, bit [63:0] now);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tuser <= mode;
        s_axis_tdata <= {3'b000, now, cnt, tag, sec, kl, kh};
        s_axis_tvalid <= 1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_pool(bit [1:0] mode, int k, bit [12:0] cnt, bit [63:0] now);
        send_req(mode, pool_kh[k], pool_kl[k], pool_sec[k], pool_tag[k], cnt, now);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(bit [CFG_ADDR_W-1:0] idx, bit [31:0] val);
        i_cfg_wr_en <= 1;
        i_cfg_addr <= idx;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
    endtask

    task automatic set_lives(bit [31:0] half_ms, bit [31:0] full_ms, bit [15:0] budget);
        drain();
        write_cfg(CFG_HALF_LIFE, half_ms);
        write_cfg(CFG_FULL_LIFE, full_ms);
        write_cfg(CFG_MAX_POINTS, {16'd0, budget});
        @(posedge i_clk);
    endtask

    task automatic random_reqs(int n, int step_ms);
        int k, sel;
        bit [1:0] mode;
        bit [12:0] cnt;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35)      now_ns += $urandom_range(0, 2000000);
            else if (sel < 70) now_ns += 64'($urandom_range(0, step_ms)) * MS;
            else if (sel < 85) now_ns += 64'($urandom_range(1, 30)) * 64'd1000000000;
            else if (sel < 95) now_ns += 0;
            else               now_ns -= 64'($urandom_range(0, 5000)) * MS;
            sel = $urandom_range(0, 99);
            mode = sel < 50 ? MODE_PUT : sel < 85 ? MODE_GET : sel < 94 ? 2'd2 : 2'd3;
            sel = $urandom_range(0, 9);
            cnt = sel == 0 ? 13'd0 : sel == 1 ? 13'($urandom_range(4096, 8191))
                                             : 13'($urandom_range(1, 4096));
            k = $urandom_range(0, KEYS - 1);
            if ($urandom_range(0, 9) == 0)
                send_req(mode, rand64(), rand64(), 16'($urandom), 16'($urandom), cnt, now_ns);
            else
                send_pool(mode, k, cnt, now_ns);
        end
    endtask

    initial begin
        for (int i = 0; i < KEYS; i++) begin
            if (i % 4 == 1) begin
                pool_kh[i] = pool_kh[i-1];
                pool_kl[i] = pool_kl[i-1];
                pool_sec[i] = pool_sec[i-1];
                pool_tag[i] = pool_tag[i-1] ^ 16'($urandom_range(1, 65535));
            end else begin
                pool_kh[i] = rand64();
                pool_kl[i] = rand64();
                pool_sec[i] = $urandom;
                pool_tag[i] = $urandom;
            end
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: count extremes, every mode, aging, expiry, time backwards
        send_req(MODE_PUT, '1, '1, '1, '1, 13'd8191, 64'd0);
        send_req(MODE_PUT, '0, '0, '0, '0, 13'd0, 64'd0);
        send_req(MODE_GET, '1, '1, '1, '1, 13'd0, 64'd5);
        send_req(MODE_GET, '0, '0, '0, 16'd1, 13'd0, 64'd5);
        send_pool(MODE_PUT, 0, 13'd4096, 64'd10);
        send_pool(MODE_PUT, 1, 13'd1, 64'd20);
        send_pool(MODE_PUT, 0, 13'd100, 64'd30);
        send_pool(MODE_GET, 0, 13'd0, 64'd40);
        send_pool(MODE_GET, 1, 13'd0, 64'd50);
        send_req(2'd2, '0, '0, '0, '0, 13'd0, 64'd31000 * MS);
        send_pool(MODE_GET, 0, 13'd0, 64'd31000 * MS);
        send_pool(MODE_GET, 0, 13'd0, 64'd31000 * MS);
        send_req(2'd3, '1, '1, '1, '1, 13'd7, 64'd20 * MS);
        send_pool(MODE_GET, 1, 13'd0, 64'd10 * MS);
        send_req(2'd2, '0, '0, '0, '0, 13'd0, 64'd61000 * MS);
        send_pool(MODE_GET, 1, 13'd0, 64'd61000 * MS);
        send_pool(MODE_PUT, 2, 13'd625, '1);
        send_pool(MODE_GET, 2, 13'd0, '1);
        send_pool(MODE_PUT, 3, 13'd626, 64'd62000 * MS);
        now_ns = 64'd70000 * MS;
        random_reqs(100, 3000);

        set_lives(32'd2000, 32'd5000, 16'd300);
        random_reqs(110, 1500);
        set_lives(32'd0, 32'd0, 16'd1);
        random_reqs(60, 100);
        set_lives('1, '1, 16'd65535);
        random_reqs(150, 3000);
        set_lives(32'd500, 32'd1500, 16'd1);
        random_reqs(80, 600);
        set_lives(32'd40000, 32'd20000, 16'd2000);
        random_reqs(40, 8000);
        quiet = 1;
        random_reqs(80, 8000);

        drain();
        repeat (1000) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
design/setp_pkg.sv
design/setp_ctrl.sv
design/setp_datapath.sv
design/scored_eviction_tag_pool.sv
verif/setp_checker.sv
verif/tb.sv
